[sv/mprs_pkg.sv]
// Package for the magnitude pivot row sort unit.
// Request/response payload types, sizes, status and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mprs_pkg;

   localparam int MAX_ROWS = 64;
   localparam int ROW_W    = 6;
   localparam int CNT_W    = ROW_W + 1;
   localparam int DATA_W   = 32;
   localparam int THR_W    = 31;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 31;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ROW      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_THRESHOLD = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ZERO_PIVOT = 2'd1;
   localparam logic [1:0] STATUS_BAD_START  = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_here;
      logic [ROW_W-1:0] row_chosen;
      logic             do_swap;
      logic [1:0]       status;
      logic             end_of_run;
   } rsp_type;

endpackage

`default_nettype wire

[sv/mprs_col_ram.sv]
// Column store: MAX_ROWS x 32 single write port, one registered read port.
// Depends on mprs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mprs_col_ram (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [mprs_pkg::ROW_W-1:0]      wr_addr,
   input  wire logic [mprs_pkg::DATA_W-1:0]     wr_data,
   input  wire logic [mprs_pkg::ROW_W-1:0]      rd_addr,
   output logic      [mprs_pkg::DATA_W-1:0]     rd_data
);

   logic [mprs_pkg::DATA_W-1:0] mem_ff [mprs_pkg::MAX_ROWS];
   logic [mprs_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/magnitude_pivot_row_sort_unit.sv]
// Top level of the magnitude pivot row sort unit.
// Depends on mprs_pkg and mprs_col_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  - Request channel: a column element (req_data.value, signed Q16.16) is
//    taken at a rising edge with start high and busy low. Elements fill
//    rows 0, 1, 2, ...; elements past MAX_ROWS are dropped.
//  - A request with req_data.last set closes the column and starts a
//    pivot run from start_row. busy stays high for the whole run.
//  - Response channel: rsp_valid pulses for one cycle per swap record in
//    rsp_data. The receiver cannot stall; every record must be taken.
//    end_of_run marks the final record. Error runs give a single record.
//  - CSR port: csr_we writes start_row (index 0) or zero_threshold
//    (index 1) from csr_wdata; write only while busy is low.
//  - Timing: a plain element is stored as it is taken. A run scans, for
//    each pivot row r, rows r to n-1 through the single magnitude
//    comparator (one column store read per cycle, registered read data),
//    then exchanges the two rows through the one write port (states
//    ST_SWAP_A, ST_SWAP_B) when rows swap. A start row at or beyond the
//    loaded rows answers in the cycle after the last element, without a run.
//  - Reset (synchronous, active high) empties the column, returns
//    start_row to 0 and zero_threshold to 1; store contents are left as is.
module magnitude_pivot_row_sort_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire mprs_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   output mprs_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [mprs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mprs_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SWAP_A = 4'b0100,
      ST_SWAP_B = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [mprs_pkg::CNT_W-1:0]      rows_ff, rows_in;
   logic [mprs_pkg::CNT_W-1:0]      n_ff, n_in;
   logic [mprs_pkg::ROW_W-1:0]      cur_ff, cur_in;
   logic [mprs_pkg::CNT_W-1:0]      j_ff, j_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [mprs_pkg::ROW_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [mprs_pkg::ROW_W-1:0]      best_idx_ff, best_idx_in;
   logic [mprs_pkg::DATA_W-1:0]     best_mag_ff, best_mag_in;
   logic [mprs_pkg::DATA_W-1:0]     best_val_ff, best_val_in;
   logic [mprs_pkg::DATA_W-1:0]     cur_val_ff, cur_val_in;
   logic [mprs_pkg::ROW_W-1:0]      start_row_ff;
   logic [mprs_pkg::THR_W-1:0]      thr_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   mprs_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   // column store port signals
   logic                            wr_en;
   logic [mprs_pkg::ROW_W-1:0]      wr_addr;
   logic [mprs_pkg::DATA_W-1:0]     wr_data;
   logic [mprs_pkg::ROW_W-1:0]      rd_addr;
   logic [mprs_pkg::DATA_W-1:0]     rd_data;

   logic                            accept;
   logic                            store_room;
   logic [mprs_pkg::CNT_W-1:0]      n_total;
   logic [mprs_pkg::DATA_W-1:0]     rd_mag;
   logic                            scan_done;
   logic                            last_row;
   logic                            zero_pivot;

   mprs_col_ram u_col_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign store_room = (rows_ff < mprs_pkg::CNT_W'(mprs_pkg::MAX_ROWS));
   assign n_total    = store_room ? rows_ff + 1'b1 : rows_ff;

   // magnitude as unsigned 32 bits; the most negative value maps to 2^31
   assign rd_mag    = rd_data[mprs_pkg::DATA_W-1] ? (~rd_data + 1'b1) : rd_data;
   assign scan_done = (j_ff == n_ff) && !rd_vld_ff;
   assign last_row  = ({1'b0, cur_ff} + 1'b1) == n_ff;
   // only the first pivot position is tested against the threshold
   assign zero_pivot = (cur_ff == start_row_ff) &&
                       ({1'b0, thr_ff} > best_mag_ff);

   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      n_in        = n_ff;
      cur_in      = cur_ff;
      j_in        = j_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      best_idx_in = best_idx_ff;
      best_mag_in = best_mag_ff;
      best_val_in = best_val_ff;
      cur_val_in  = cur_val_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en   = 1'b0;
      wr_addr = rows_ff[mprs_pkg::ROW_W-1:0];
      wr_data = req_data.value;
      rd_addr = j_ff[mprs_pkg::ROW_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_en   = store_room;
               rows_in = n_total;
               if (req_data.last) begin
                  rows_in = '0;
                  if ({1'b0, start_row_ff} >= n_total) begin
                     rsp_valid_in           = 1'b1;
                     rsp_data_in.row_here   = start_row_ff;
                     rsp_data_in.row_chosen = start_row_ff;
                     rsp_data_in.do_swap    = 1'b0;
                     rsp_data_in.status     = mprs_pkg::STATUS_BAD_START;
                     rsp_data_in.end_of_run = 1'b1;
                  end else begin
                     n_in     = n_total;
                     cur_in   = start_row_ff;
                     j_in     = {1'b0, start_row_ff};
                     state_in = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            // issue one read a cycle
            if (j_ff < n_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = j_ff[mprs_pkg::ROW_W-1:0];
               j_in      = j_ff + 1'b1;
            end
            // compare the data read last cycle
            if (rd_vld_ff) begin
               if (rd_idx_ff == cur_ff) begin
                  best_idx_in = cur_ff;
                  best_mag_in = rd_mag;
                  best_val_in = rd_data;
                  cur_val_in  = rd_data;
               end else if (rd_mag > best_mag_ff) begin
                  // strict compare: ties keep the earlier row
                  best_idx_in = rd_idx_ff;
                  best_mag_in = rd_mag;
                  best_val_in = rd_data;
               end
            end
            if (scan_done) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.row_here   = cur_ff;
               rsp_data_in.row_chosen = best_idx_ff;
               if (zero_pivot) begin
                  rsp_data_in.do_swap    = 1'b0;
                  rsp_data_in.status     = mprs_pkg::STATUS_ZERO_PIVOT;
                  rsp_data_in.end_of_run = 1'b1;
                  state_in               = ST_IDLE;
               end else begin
                  rsp_data_in.do_swap    = (best_idx_ff != cur_ff);
                  rsp_data_in.status     = mprs_pkg::STATUS_OK;
                  rsp_data_in.end_of_run = last_row;
                  if (best_idx_ff != cur_ff) begin
                     state_in = ST_SWAP_A;
                  end else if (last_row) begin
                     state_in = ST_IDLE;
                  end else begin
                     cur_in = cur_ff + 1'b1;
                     j_in   = {1'b0, cur_ff} + 1'b1;
                  end
               end
            end
         end

         ST_SWAP_A: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = best_val_ff;
            state_in = ST_SWAP_B;
         end

         ST_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = cur_val_ff;
            if (last_row) begin
               state_in = ST_IDLE;
            end else begin
               cur_in   = cur_ff + 1'b1;
               j_in     = {1'b0, cur_ff} + 1'b1;
               state_in = ST_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_row_ff <= '0;
         thr_ff       <= mprs_pkg::THR_W'(1);
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               mprs_pkg::CSR_START_ROW: begin
                  start_row_ff <= csr_wdata[mprs_pkg::ROW_W-1:0];
               end
               mprs_pkg::CSR_ZERO_THRESHOLD: begin
                  thr_ff <= csr_wdata[mprs_pkg::THR_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      cur_ff      <= cur_in;
      j_ff        <= j_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_mag_ff <= best_mag_in;
      best_val_ff <= best_val_in;
      cur_val_ff  <= cur_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   a_eor_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_run |-> !busy)
      else $error("end of run record while sequencer still active");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.end_of_run |-> busy)
      else $error("intermediate record with sequencer idle");

   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != mprs_pkg::STATUS_OK)
         |-> rsp_data.end_of_run && !rsp_data.do_swap)
      else $error("error record must be final and not swap");

   a_swap_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.do_swap |-> rsp_data.row_here != rsp_data.row_chosen)
      else $error("swap record names the same row twice");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff <= n_ff))
      else $error("scan pointer ran past loaded rows");

endmodule

`default_nettype wire

[tb/sv/tb_magnitude_pivot_row_sort_unit.sv]
// Testbench for magnitude_pivot_row_sort_unit: streams matrix columns into the
// unit and checks every swap record against a behavioral pivot predictor.
// Depends on mprs_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_magnitude_pivot_row_sort_unit;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 20;
   localparam int PHASE_ITEMS  = 8;
   localparam int MAX_PRINTS   = 100;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   mprs_pkg::req_type                   req_data;
   logic                                rsp_valid;
   mprs_pkg::rsp_type                   rsp_data;
   logic                                csr_we;
   logic [mprs_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [mprs_pkg::CSR_DAT_W-1:0]      csr_wdata;

   magnitude_pivot_row_sort_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the column and of both registers.
   // ---------------------------------------------------------------------
   logic [mprs_pkg::DATA_W-1:0] column_copy [mprs_pkg::MAX_ROWS];
   int unsigned                 rows_held;
   logic [mprs_pkg::ROW_W-1:0]  pivot_from;     // start_row
   logic [mprs_pkg::THR_W-1:0]  zero_limit;     // zero_threshold

   mprs_pkg::rsp_type           pending_swap_records [$];
   int                          error_count;
   int                          cycle_count;
   int                          items_sent;
   bit                          gaps_on;
   logic [mprs_pkg::DATA_W-1:0] prev_value;     // source of tied magnitudes

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit: worst case is far below this even with every column at 64 rows.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Exact Q16.16 magnitude as unsigned; 0x80000000 maps onto itself (2^31).
   function automatic logic [mprs_pkg::DATA_W-1:0] magnitude(
      input logic [mprs_pkg::DATA_W-1:0] v);
      return v[mprs_pkg::DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic void queue_record(input int unsigned here, input int unsigned chosen,
                                        input logic swp, input logic [1:0] st,
                                        input logic eor);
      mprs_pkg::rsp_type rec;
      rec.row_here   = here[mprs_pkg::ROW_W-1:0];
      rec.row_chosen = chosen[mprs_pkg::ROW_W-1:0];
      rec.do_swap    = swp;
      rec.status     = st;
      rec.end_of_run = eor;
      pending_swap_records.push_back(rec);
   endfunction

   // Store one accepted element; on last, run selection-sort pivoting and
   // queue the swap records the unit owes.
   function automatic void pivot_after_element(input logic [mprs_pkg::DATA_W-1:0] value,
                                               input logic last);
      int unsigned                 n, cur, j, best;
      logic [mprs_pkg::DATA_W-1:0] best_mag, m, t;
      if (rows_held < mprs_pkg::MAX_ROWS) begin
         column_copy[rows_held] = value;
         rows_held++;
      end
      if (!last)
         return;
      n         = rows_held;
      rows_held = 0;
      if (pivot_from >= n) begin
         queue_record(pivot_from, pivot_from, 1'b0, mprs_pkg::STATUS_BAD_START, 1'b1);
         return;
      end
      for (cur = pivot_from; cur < n; cur++) begin
         best     = cur;
         best_mag = magnitude(column_copy[cur]);
         // strict compare: ties keep the earlier row
         for (j = cur + 1; j < n; j++) begin
            m = magnitude(column_copy[j]);
            if (m > best_mag) begin
               best_mag = m;
               best     = j;
            end
         end
         // only the first pivot is held against the threshold
         if (cur == pivot_from && best_mag < {1'b0, zero_limit}) begin
            queue_record(cur, best, 1'b0, mprs_pkg::STATUS_ZERO_PIVOT, 1'b1);
            return;
         end
         if (best != cur) begin
            t                 = column_copy[cur];
            column_copy[cur]  = column_copy[best];
            column_copy[best] = t;
         end
         queue_record(cur, best, best != cur, mprs_pkg::STATUS_OK, cur + 1 == n);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: results cannot be stalled, so every strobe is taken.
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      mprs_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_swap_records.size() == 0) begin
            report_mismatch($sformatf("unexpected record row_here=%0d", rsp_data.row_here));
         end else begin
            want = pending_swap_records.pop_front();
            check_field("row_here",   rsp_data.row_here,   want.row_here);
            check_field("row_chosen", rsp_data.row_chosen, want.row_chosen);
            check_field("do_swap",    rsp_data.do_swap,    want.do_swap);
            check_field("status",     rsp_data.status,     want.status);
            check_field("end_of_run", rsp_data.end_of_run, want.end_of_run);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers: inputs change on the falling edge only.
   // ---------------------------------------------------------------------

   // One request: optional idle gap, then hold start until busy is low at
   // a rising edge. Returns right after that edge with start still high.
   task automatic send_element(input logic [mprs_pkg::DATA_W-1:0] value, input logic last);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(99) < 26) begin
         start = 1'b0;
         gap   = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      start          = 1'b1;
      req_data.value = value;
      req_data.last  = last;
      do @(posedge clock); while (busy);
      pivot_after_element(value, last);
      items_sent++;
   endtask

   // Drop start, drain all owed records, then let an in-flight exchange finish.
   task automatic wait_quiet();
      @(negedge clock);
      start = 1'b0;
      while (pending_swap_records.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [mprs_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [mprs_pkg::CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         mprs_pkg::CSR_START_ROW:      pivot_from = data[mprs_pkg::ROW_W-1:0];
         mprs_pkg::CSR_ZERO_THRESHOLD: zero_limit = data[mprs_pkg::THR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Mix of full-range words, extremes, small values and tied magnitudes.
   function automatic logic [mprs_pkg::DATA_W-1:0] pick_value();
      logic [mprs_pkg::DATA_W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4:          v = $urandom_range(0, 7) << $urandom_range(0, 20);
         5:          v = 32'h8000_0000;
         6:          v = 32'h7FFF_FFFF;
         7:          v = '0;
         8:          v = $urandom_range(1) ? prev_value : ~prev_value + 1'b1;
         default:    v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0001;
      endcase
      prev_value = v;
      return v;
   endfunction

   task automatic send_random_column(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_element(pick_value(), i == n - 1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset values: start row 0, threshold 1, so a lone zero is a zero pivot.
   task automatic test_reset_defaults();
      send_element(32'h0000_0000, 1'b1);
      send_element(32'h0000_0001, 1'b1);
      wait_quiet();
   endtask

   // Most negative value has the largest magnitude; ties keep the upper row.
   task automatic test_magnitude_extremes();
      write_register(mprs_pkg::CSR_ZERO_THRESHOLD, '0);
      send_element(32'h0000_0001, 1'b0);
      send_element(32'h7FFF_FFFF, 1'b0);
      send_element(32'hFFFF_FFFF, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'h8000_0001, 1'b1);
      send_element(32'h0005_0000, 1'b0);
      send_element(32'hFFFB_0000, 1'b0);
      send_element(32'h0005_0000, 1'b1);
      wait_quiet();
   endtask

   // Threshold at its top: tie below it aborts, equal passes, 2^31 passes
   // and later tiny pivots are not re-tested.
   task automatic test_zero_pivot();
      write_register(mprs_pkg::CSR_ZERO_THRESHOLD, 31'h7FFF_FFFF);
      send_element(32'h7FFF_FFFE, 1'b0);
      send_element(32'h8000_0002, 1'b1);
      send_element(32'h7FFF_FFFF, 1'b1);
      send_element(32'h0000_0003, 1'b0);
      send_element(32'h8000_0000, 1'b0);
      send_element(32'h0000_0000, 1'b1);
      wait_quiet();
   endtask

   // Start row at or past the loaded rows, and a run that starts mid-column.
   task automatic test_start_row_limits();
      write_register(mprs_pkg::CSR_ZERO_THRESHOLD, 31'd1);
      write_register(mprs_pkg::CSR_START_ROW, 31'd63);
      send_random_column(3);
      wait_quiet();
      write_register(mprs_pkg::CSR_START_ROW, 31'd2);
      send_random_column(2);
      wait_quiet();
      write_register(mprs_pkg::CSR_START_ROW, 31'd1);
      send_element(32'h0000_0002, 1'b0);
      send_element(32'h0000_0001, 1'b0);
      send_element(32'hFFFF_FFF0, 1'b1);
      wait_quiet();
   endtask

   // Two elements past a full store are dropped; last still starts the run.
   // The whole column goes back to back with no idle cycles.
   task automatic test_store_full();
      write_register(mprs_pkg::CSR_ZERO_THRESHOLD, '0);
      write_register(mprs_pkg::CSR_START_ROW, 31'd62);
      gaps_on = 1'b0;
      send_random_column(mprs_pkg::MAX_ROWS + 2);
      gaps_on = 1'b1;
      wait_quiet();
   endtask

   // Random columns in phases; registers change only between phases.
   task automatic test_random_columns();
      int unsigned                phase, phase_items, n;
      logic [mprs_pkg::ROW_W-1:0] row_sel;
      logic [mprs_pkg::THR_W-1:0] thr_sel;
      int                         first_item;
      phase      = 0;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         // one phase in four runs back to back with no idle cycles
         gaps_on = (phase % 4 != 2);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: row_sel = '0;
            5, 6, 7:       row_sel = mprs_pkg::ROW_W'($urandom_range(1, 3));
            8:             row_sel = mprs_pkg::ROW_W'($urandom_range(0, 63));
            default:       row_sel = 6'd63;
         endcase
         case ($urandom_range(5))
            0:       thr_sel = '0;
            1:       thr_sel = 31'd1;
            2:       thr_sel = 31'h7FFF_FFFF;
            3:       thr_sel = mprs_pkg::THR_W'($urandom_range(0, 32'h0003_0000));
            default: thr_sel = mprs_pkg::THR_W'($urandom);
         endcase
         write_register(mprs_pkg::CSR_START_ROW, {25'd0, row_sel});
         write_register(mprs_pkg::CSR_ZERO_THRESHOLD, thr_sel);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && items_sent - first_item < RANDOM_ITEMS) begin
            // mostly short columns, now and then a deep one
            n = ($urandom_range(9) == 0) ? $urandom_range(12, mprs_pkg::MAX_ROWS)
                                         : $urandom_range(1, 8);
            // keep the total near the item budget
            if (n > RANDOM_ITEMS - (items_sent - first_item))
               n = RANDOM_ITEMS - (items_sent - first_item);
            send_random_column(n);
            phase_items += n;
         end
         wait_quiet();
         phase++;
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      error_count    = 0;
      cycle_count    = 0;
      items_sent     = 0;
      gaps_on        = 1'b1;
      prev_value     = 32'h0001_0000;
      rows_held      = 0;
      pivot_from     = '0;
      zero_limit     = 31'd1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_magnitude_extremes();
      test_zero_pivot();
      test_start_row_limits();
      test_store_full();
      test_random_columns();

      wait_quiet();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_swap_records.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
